FILE: src/nas_pkg.sv
// Shared types, constants and helper function for the next alarm selector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package nas_pkg;

    // alarm bank size and special indexes
    localparam int NUM_ALARMS = 8;
    localparam int IDX_W      = 3;
    localparam int RES_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic [IDX_W-1:0] DAILY_IDX = 3'd7;
    localparam logic [RES_W-1:0] NONE_IDX  = 4'd8;

    // minute-of-day and distance widths
    localparam int MOD_W  = 11;
    localparam int DIST_W = 14;
    localparam int CALC_W = 16;

    localparam logic [MOD_W-1:0]  MIN_PER_HOUR = 11'd60;
    localparam logic [DIST_W-1:0] DAY_MIN      = 14'd1440;
    localparam logic [DIST_W-1:0] WEEK_MIN     = 14'd10080;

    // one alarm register: active flag, hour, minute
    typedef struct packed {
        logic       active;
        logic [4:0] hour;
        logic [5:0] minute;
    } alarm_t;

    // input beat
    typedef struct packed {
        logic [2:0] current_day;
        logic [4:0] current_hour;
        logic [5:0] current_minute;
    } in_t;

    // result beat
    typedef struct packed {
        logic [RES_W-1:0] first_alarm;
        logic [RES_W-1:0] second_alarm;
    } out_t;

    // per-alarm distance with eligibility for each search
    typedef struct packed {
        logic              first_ok;
        logic              second_ok;
        logic [DIST_W-1:0] span;
    } dist_t;

    // search tree node
    typedef struct packed {
        logic              ok;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] span;
    } cand_t;

    // lo holds the lower indexes, so it keeps ties
    function automatic cand_t pick(cand_t lo, cand_t hi);
        cand_t res;
        res = lo;
        if (hi.ok && (!lo.ok || (hi.span < lo.span)))
        begin
            res = hi;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: src/next_alarm_selector.sv
// Next alarm selector: nearest and second-nearest of eight alarms.
// Three-stage pipeline from input beat to result beat (input register, distance
// register, result register) with per-stage valid flags and back-pressure;
// throughput one beat per cycle while the result side does not stall.
// Reset clears all alarm registers (inactive) and all pipeline valid flags.
// Depends on nas_pkg, nas_dist and nas_search.
`default_nettype none

module next_alarm_selector
    import nas_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    // input channel
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire in_t               in_data,
    // result channel
    output logic                   out_valid,
    input  wire                    out_stall,
    output out_t                   out_data,
    // configuration channel
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    alarm_t alarm_reg [NUM_ALARMS];

    logic s1_valid_reg, s1_valid_next;
    in_t  s1_item_reg;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    out_t out_item_reg, out_item_next;

    logic [NUM_ALARMS-1:0]             ok1_reg, ok1_next;
    logic [NUM_ALARMS-1:0]             ok2_reg, ok2_next;
    logic [NUM_ALARMS-1:0][DIST_W-1:0] dist_reg, dist_next;

    logic s1_ready, s2_ready, out_ready;
    logic [MOD_W-1:0] now_min;
    dist_t            dist_res [NUM_ALARMS];

    logic [NUM_ALARMS-1:0] ok2_masked;
    logic [RES_W-1:0]      first_best;
    logic [RES_W-1:0]      second_best;

    // configuration writes, indexes past the bank are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                alarm_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_ALARMS)))
        begin
            alarm_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
    end

    // stage flow control
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;

    assign s1_valid_next  = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg <= in_data;
        end
    end

    // per-alarm distances
    assign now_min = 11'(s1_item_reg.current_hour) * MIN_PER_HOUR
                   + 11'(s1_item_reg.current_minute);

    for (genvar g = 0; g < NUM_ALARMS; g++)
    begin : g_dist
        nas_dist u_dist (
            .alarm     (alarm_reg[g]),
            .alarm_idx (IDX_W'(g)),
            .day       (s1_item_reg.current_day),
            .now_min   (now_min),
            .result    (dist_res[g])
        );
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            ok1_next[i]  = dist_res[i].first_ok;
            ok2_next[i]  = dist_res[i].second_ok;
            dist_next[i] = dist_res[i].span;
        end
    end

    // distance register
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            ok1_reg  <= ok1_next;
            ok2_reg  <= ok2_next;
            dist_reg <= dist_next;
        end
    end

    // first search, then second search without the first winner
    nas_search u_first (
        .ok   (ok1_reg),
        .span (dist_reg),
        .best (first_best)
    );

    always_comb
    begin
        if (first_best == NONE_IDX)
        begin
            ok2_masked = '0;
        end
        else
        begin
            ok2_masked = ok2_reg & ~(NUM_ALARMS'(1) << first_best[IDX_W-1:0]);
        end
    end

    nas_search u_second (
        .ok   (ok2_masked),
        .span (dist_reg),
        .best (second_best)
    );

    assign out_item_next.first_alarm  = first_best;
    assign out_item_next.second_alarm = second_best;

    // result register
    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

FILE: src/nas_dist.sv
// Minutes until one alarm fires, seen from the current day and minute of day.
// Depends on nas_pkg for alarm_t, dist_t and the time constants.
`default_nettype none

module nas_dist
    import nas_pkg::*;
(
    input  wire alarm_t           alarm,
    input  wire [IDX_W-1:0]       alarm_idx,
    input  wire [2:0]             day,
    input  wire [MOD_W-1:0]       now_min,
    output dist_t                 result
);

    logic [MOD_W-1:0]         alarm_min;
    logic                     passed;
    logic                     is_daily;
    logic                     same_day;
    logic [3:0]               days_wide;
    logic [IDX_W-1:0]         days;
    logic [DIST_W-1:0]        offset;
    logic signed [CALC_W-1:0] total;

    // alarm minute of day and whether it is already behind us today
    assign alarm_min = 11'(alarm.hour) * MIN_PER_HOUR + 11'(alarm.minute);
    assign passed    = alarm_min < now_min;
    assign is_daily  = alarm_idx == DAILY_IDX;
    assign same_day  = !is_daily && (alarm_idx == day);

    // days ahead for a weekday alarm on another day
    always_comb
    begin
        if (alarm_idx < day)
        begin
            days_wide = 4'd7 - {1'b0, day} + {1'b0, alarm_idx};
        end
        else
        begin
            days_wide = {1'b0, alarm_idx} - {1'b0, day};
        end
        days = days_wide[IDX_W-1:0];
    end

    // offset added to the raw difference
    always_comb
    begin
        if (is_daily)
        begin
            offset = passed ? DAY_MIN : '0;
        end
        else if (same_day)
        begin
            offset = passed ? WEEK_MIN : '0;
        end
        else
        begin
            offset = 14'(days) * DAY_MIN;
        end
    end

    // signed total, negative means the alarm takes no part
    assign total = $signed({5'b0, alarm_min}) - $signed({5'b0, now_min})
                 + $signed({2'b0, offset});

    assign result.span      = total[DIST_W-1:0];
    assign result.second_ok = alarm.active && !total[CALC_W-1];
    assign result.first_ok  = alarm.active && !total[CALC_W-1] && !(same_day && passed);

endmodule

`default_nettype wire

FILE: src/nas_search.sv
// Registered-free tournament tree that finds the nearest eligible alarm.
// Depends on nas_pkg for cand_t and the pick function; lower index wins ties.
`default_nettype none

module nas_search
    import nas_pkg::*;
(
    input  wire [NUM_ALARMS-1:0]             ok,
    input  wire [NUM_ALARMS-1:0][DIST_W-1:0] span,
    output logic [RES_W-1:0]                 best
);

    cand_t leaf [NUM_ALARMS];
    cand_t lvl1 [NUM_ALARMS/2];
    cand_t lvl2 [NUM_ALARMS/4];
    cand_t root;

    // leaves
    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            leaf[i].ok   = ok[i];
            leaf[i].idx  = IDX_W'(i);
            leaf[i].span = span[i];
        end
    end

    // three levels of pairwise picks
    always_comb
    begin
        for (int i = 0; i < NUM_ALARMS/2; i++)
        begin
            lvl1[i] = pick(leaf[2*i], leaf[2*i+1]);
        end
        for (int i = 0; i < NUM_ALARMS/4; i++)
        begin
            lvl2[i] = pick(lvl1[2*i], lvl1[2*i+1]);
        end
        root = pick(lvl2[0], lvl2[1]);
    end

    assign best = root.ok ? {1'b0, root.idx} : NONE_IDX;

endmodule

`default_nettype wire

FILE: tb/sv/tb_next_alarm_selector.sv
// Self-checking bench for next_alarm_selector: directed and random time queries
// against alarm banks written over the config channel, scored by a predictor class.
// Depends on nas_pkg and the next_alarm_selector RTL.
`default_nettype none

module tb_next_alarm_selector
    import nas_pkg::*;
;

    localparam int HOUR_MINUTES    = 60;
    localparam int DAY_MINUTES     = 1440;
    localparam int WEEK_MINUTES    = 10080;
    localparam int WEEK_DAYS       = 7;
    localparam int PIPE_LATENCY    = 3;
    localparam int HOLD_CYCLES     = 64;
    localparam int STUCK_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 14;
    localparam int PHASE_BEATS     = 125;
    localparam int IN_W            = $bits(in_t);
    localparam logic [CFG_IDX_W-1:0] STRAY_LO_IDX = CFG_IDX_W'(NUM_ALARMS);
    localparam logic [CFG_IDX_W-1:0] STRAY_HI_IDX = '1;

    // bank styles for the random phases
    typedef enum int
    {
        BANK_MIXED,
        BANK_TIED,
        BANK_RAW,
        BANK_SPARSE
    } bank_style_t;

    // predicts the alarm picks and keeps the ones still owed by the block
    class alarm_scoreboard;
        alarm_t bank [NUM_ALARMS];
        out_t   owed_picks [$];
        int     errors;
        int     queries;
        int     results;

        function new();
            foreach (bank[i])
            begin
                bank[i] = '0;
            end
            errors  = 0;
            queries = 0;
            results = 0;
        endfunction

        function void set_alarm(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx < NUM_ALARMS)
            begin
                bank[idx[IDX_W-1:0]] = val;
            end
        endfunction

        function int pending();
            return owed_picks.size();
        endfunction

        // minutes until alarm i fires, -1 when it takes no part
        function int minutes_until(int i, int day, int now, bit second);
            int at;
            int gap;
            if (!bank[i].active)
            begin
                return -1;
            end
            at  = int'(bank[i].hour) * HOUR_MINUTES + int'(bank[i].minute);
            gap = at - now;
            if (i == int'(DAILY_IDX))
            begin
                if (at < now)
                begin
                    gap += DAY_MINUTES;
                end
            end
            else if (i == day)
            begin
                // passed today: skipped first, one week later second
                if (at < now)
                begin
                    if (!second)
                    begin
                        return -1;
                    end
                    gap += WEEK_MINUTES;
                end
            end
            else if (i < day)
            begin
                gap += (WEEK_DAYS - day + i) * DAY_MINUTES;
            end
            else
            begin
                gap += (i - day) * DAY_MINUTES;
            end
            return (gap >= 0) ? gap : -1;
        endfunction

        // lowest distance wins, lower index keeps ties
        function int nearest(int day, int now, bit second, int skip);
            int best;
            int best_gap;
            int gap;
            best     = int'(NONE_IDX);
            best_gap = 0;
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                if (i != skip)
                begin
                    gap = minutes_until(i, day, now, second);
                    if (gap >= 0 && (best == int'(NONE_IDX) || gap < best_gap))
                    begin
                        best     = i;
                        best_gap = gap;
                    end
                end
            end
            return best;
        endfunction

        function void note_input(in_t beat);
            int   day;
            int   now;
            int   first;
            out_t picks;
            day   = int'(beat.current_day);
            now   = int'(beat.current_hour) * HOUR_MINUTES + int'(beat.current_minute);
            first = nearest(day, now, 1'b0, int'(NONE_IDX));
            picks.first_alarm  = RES_W'(first);
            picks.second_alarm = NONE_IDX;
            if (first != int'(NONE_IDX))
            begin
                picks.second_alarm = RES_W'(nearest(day, now, 1'b1, first));
            end
            owed_picks.push_back(picks);
            queries++;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(out_t beat);
            out_t want;
            results++;
            if (owed_picks.size() == 0)
            begin
                report($sformatf("result beat %0d/%0d with nothing owed",
                                 beat.first_alarm, beat.second_alarm));
                return;
            end
            want = owed_picks.pop_front();
            if (beat.first_alarm !== want.first_alarm)
            begin
                report($sformatf("result %0d first_alarm %0d, predicted %0d",
                                 results, beat.first_alarm, want.first_alarm));
            end
            if (beat.second_alarm !== want.second_alarm)
            begin
                report($sformatf("result %0d second_alarm %0d, predicted %0d",
                                 results, beat.second_alarm, want.second_alarm));
            end
        endtask

        task wrap_up();
            if (owed_picks.size() != 0)
            begin
                report($sformatf("%0d predicted results never came", owed_picks.size()));
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_t                   in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_t                  out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    alarm_scoreboard board;
    alarm_t          plan [NUM_ALARMS];
    bit              calm;
    bit              hold_off_req;
    int              hold_left;
    int              stuck;
    int              cfg_writes;
    int              bank_settings;

    next_alarm_selector DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog on cycles with no handshake on any channel
    initial
    begin
        stuck = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                stuck = 0;
            end
            else
            begin
                stuck++;
            end
            if (stuck >= STUCK_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", stuck);
                $display("next_alarm_selector verification failed");
                $finish;
            end
        end
    end

    // result side: check accepted beats, random stall, long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                board.check_result(out_data);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(0, 99) < 25);
            end
        end
    end

    function automatic alarm_t make_alarm(bit on, int hh, int mm);
        alarm_t a;
        a.active = on;
        a.hour   = 5'(hh);
        a.minute = 6'(mm);
        return a;
    endfunction

    function automatic in_t make_query(int d, int hh, int mm);
        in_t q;
        q.current_day    = 3'(d);
        q.current_hour   = 5'(hh);
        q.current_minute = 6'(mm);
        return q;
    endfunction

    // mostly legal times, some landing on an alarm time, some raw bits
    function automatic in_t random_query();
        logic [IN_W-1:0] raw;
        in_t             q;
        alarm_t          pick;
        int              roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
        begin
            raw = IN_W'($urandom);
            q   = raw;
        end
        else
        begin
            q = make_query($urandom_range(0, 6), $urandom_range(0, 23), $urandom_range(0, 59));
            if (roll < 35)
            begin
                pick = board.bank[IDX_W'($urandom_range(0, NUM_ALARMS - 1))];
                q.current_hour   = pick.hour;
                q.current_minute = pick.minute;
            end
        end
        return q;
    endfunction

    function automatic void random_plan(bank_style_t style);
        int                    share_h;
        int                    share_m;
        logic [CFG_DATA_W-1:0] raw;
        share_h = $urandom_range(0, 23);
        share_m = $urandom_range(0, 59);
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            raw = CFG_DATA_W'($urandom);
            case (style)
                BANK_MIXED:
                    plan[i] = make_alarm($urandom_range(0, 1) == 1, $urandom_range(0, 23),
                                         $urandom_range(0, 59));
                BANK_TIED:
                    plan[i] = make_alarm($urandom_range(0, 1) == 1, share_h, share_m);
                BANK_RAW:
                    plan[i] = raw;
                default:
                    plan[i] = make_alarm($urandom_range(0, 7) == 0, $urandom_range(0, 23),
                                         $urandom_range(0, 59));
            endcase
        end
    endfunction

    function automatic void clear_plan();
        foreach (plan[i])
        begin
            plan[i] = '0;
        end
    endfunction

    // one config beat, valid left high for the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.set_alarm(idx, val);
        cfg_writes++;
    endtask

    // write the whole plan, optionally one write to an unmapped index
    task automatic program_bank(input bit add_stray);
        for (int i = 0; i < NUM_ALARMS; i++)
        begin
            write_reg(CFG_IDX_W'(i), plan[i]);
        end
        if (add_stray)
        begin
            write_reg(CFG_IDX_W'($urandom_range(int'(STRAY_LO_IDX), int'(STRAY_HI_IDX))),
                      CFG_DATA_W'($urandom));
        end
        cfg_valid <= 1'b0;
        bank_settings++;
    endtask

    // one query beat with an optional idle gap ahead of it
    task automatic offer(input in_t beat);
        int gap;
        if (!calm && $urandom_range(0, 99) < 13)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_input(beat);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() > 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        hold_off_req  = 1'b0;
        cfg_writes    = 0;
        bank_settings = 0;
        board         = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bank, all zero, unmapped writes must be ignored
        clear_plan();
        program_bank(1'b0);
        write_reg(STRAY_LO_IDX, '1);
        write_reg(STRAY_HI_IDX, '1);
        cfg_valid <= 1'b0;
        offer(make_query(0, 0, 0));
        offer(make_query(6, 23, 59));
        drain();

        // daily only: due now, then passed and moved to tomorrow
        clear_plan();
        plan[DAILY_IDX] = make_alarm(1'b1, 7, 30);
        program_bank(1'b0);
        offer(make_query(3, 7, 30));
        offer(make_query(3, 7, 31));
        drain();

        // weekday against daily tie, passed weekday counted a week later
        clear_plan();
        plan[2]         = make_alarm(1'b1, 6, 0);
        plan[5]         = make_alarm(1'b1, 8, 0);
        plan[DAILY_IDX] = make_alarm(1'b1, 6, 0);
        program_bank(1'b0);
        offer(make_query(2, 5, 0));
        offer(make_query(2, 7, 0));
        offer(make_query(7, 31, 63));
        offer(make_query(5, 8, 0));
        offer(make_query(6, 6, 0));
        drain();

        // every bit set: all active at the out-of-range time
        foreach (plan[i])
        begin
            plan[i] = '1;
        end
        program_bank(1'b0);
        offer(make_query(0, 0, 0));
        offer(make_query(6, 23, 59));
        offer(make_query(7, 31, 63));
        offer(make_query(3, 31, 63));
        drain();

        // all active at midnight: ties everywhere
        foreach (plan[i])
        begin
            plan[i] = make_alarm(1'b1, 0, 0);
        end
        program_bank(1'b0);
        offer(make_query(0, 0, 0));
        offer(make_query(4, 12, 0));
        offer(make_query(6, 23, 59));
        drain();

        // negative distances drop out, leaving no first alarm
        clear_plan();
        plan[1]         = make_alarm(1'b1, 0, 0);
        plan[DAILY_IDX] = make_alarm(1'b1, 0, 0);
        program_bank(1'b0);
        offer(make_query(0, 31, 63));
        offer(make_query(0, 0, 0));
        drain();

        // single weekday alarm: passed, not yet, exactly now
        clear_plan();
        plan[3] = make_alarm(1'b1, 6, 0);
        program_bank(1'b0);
        offer(make_query(3, 7, 0));
        offer(make_query(3, 5, 0));
        offer(make_query(3, 6, 0));
        drain();

        // random phases, a fresh bank each
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_plan(bank_style_t'(p % 4));
            program_bank(p % 3 == 0);
            calm = (p == 5);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (p == 9 && k == 40)
                begin
                    hold_off_req = 1'b1;
                end
                if (p == 11 && k == 60)
                begin
                    drain();
                end
                offer(random_query());
            end
            drain();
        end
        calm = 1'b0;

        board.wrap_up();
        $display("ran %0d query beats against %0d alarm bank settings (%0d register writes)",
                 board.queries, bank_settings, cfg_writes);
        $display("covered ties, passed alarms, empty banks, raw register and time bits, %0d results",
                 board.results);
        if (board.errors == 0)
        begin
            $display("next_alarm_selector verification clean");
        end
        else
        begin
            $display("next_alarm_selector verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
